### hw/rtl/ordered_table_engine_macros.svh
// assertion macros for the ordered table engine
// used by the top level; no other dependencies
`ifndef ORDERED_TABLE_ENGINE_MACROS_SVH
`define ORDERED_TABLE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define OTE_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ordered table engine check failed");
`define OTE_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ordered table engine check failed");
`else
`define OTE_ASSERT_IMPLY(name, clk, rst_n, pre, post)
`define OTE_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

### hw/rtl/ote_pkg.sv
// shared types, codes and defaults of the ordered table engine
// no dependencies
`default_nettype none

package ote_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SORTED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_APPEND,
    OP_REMOVE,
    OP_SHUP_POS,
    OP_SHUP_LO,
    OP_SHUP_STEP,
    OP_SHDN_START,
    OP_SHDN_STEP,
    OP_SEARCH_START,
    OP_PROBE,
    OP_NARROW,
    OP_READ_ISSUE,
    OP_READ_CAP
  } ote_op_t;

  typedef struct packed {
    ote_op_t         op;
    logic            load_out;
    logic [ST_W-1:0] status;
  } ote_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt;
    logic pos_ge;
    logic srch_done;
    logic shup_done;
    logic shdn_done;
  } ote_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ote_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ote_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/ote_datapath.sv
// datapath: entry count, search and shift pointers, table ram, result registers
// depends on ote_pkg and ote_ram
`default_nettype none

module ote_datapath #(
  parameter int CAPACITY   = ote_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ote_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ote_pkg::ote_cmd_t          cmd,
  output ote_pkg::ote_stat_t         stat,
  input  logic [ote_pkg::POS_W-1:0]  in_position,
  input  logic [ote_pkg::VAL_W-1:0]  in_value,
  output logic [ote_pkg::ST_W-1:0]   out_status,
  output logic [ote_pkg::POS_W-1:0]  out_count,
  output logic [ote_pkg::VAL_W-1:0]  out_read_value,
  output logic [ote_pkg::POS_W-1:0]  out_placed_index
);

  import ote_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]         count_r;
  logic                  pend_r;
  logic [POS_W-1:0]      pos_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CW-1:0]         p_r;
  logic [CW-1:0]         ptr_r;
  logic [AW-1:0]         wa_r;
  logic [CW-1:0]         lo_r;
  logic [CW-1:0]         hi_r;
  logic [CW-1:0]         mid_r;
  logic [VALUE_BITS-1:0] res_rd_r;
  logic [CW-1:0]         res_placed_r;
  logic [ST_W-1:0]       out_status_r;
  logic [POS_W-1:0]      out_count_r;
  logic [VAL_W-1:0]      out_rd_r;
  logic [POS_W-1:0]      out_placed_r;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;

  logic [CW:0]   sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] ptr_dec;
  logic [CW:0]   ptr_inc;
  logic [CW-1:0] pos_c;
  logic          shup_at;
  logic          shdn_more;

  assign sum       = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = sum[CW:1];
  assign ptr_dec   = ptr_r - CW'(1);
  assign ptr_inc   = {1'b0, ptr_r} + (CW+1)'(1);
  assign pos_c     = CW'(pos_r);
  assign shup_at   = (ptr_r == p_r);
  assign shdn_more = (ptr_inc < {1'b0, count_r});

  assign stat.full      = (count_r >= CW'(CAPACITY));
  assign stat.empty     = (count_r == '0);
  assign stat.pos_gt    = (CMPW'(pos_r) > CMPW'(count_r));
  assign stat.pos_ge    = (CMPW'(pos_r) >= CMPW'(count_r));
  assign stat.srch_done = (lo_r >= hi_r);
  assign stat.shup_done = shup_at && !pend_r;
  assign stat.shdn_done = !shdn_more && !pend_r;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val_r;
    raddr = '0;
    case (cmd.op)
      OP_APPEND: begin
        we    = 1'b1;
        waddr = count_r[AW-1:0];
      end
      OP_SHUP_STEP: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = wa_r;
          wdata = rdata;
        end else if (shup_at) begin
          we    = 1'b1;
          waddr = p_r[AW-1:0];
        end
        if (!shup_at) begin
          raddr = ptr_dec[AW-1:0];
        end
      end
      OP_SHDN_STEP: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = wa_r;
          wdata = rdata;
        end
        if (shdn_more) begin
          raddr = ptr_inc[AW-1:0];
        end
      end
      OP_PROBE: begin
        raddr = mid[AW-1:0];
      end
      OP_READ_ISSUE: begin
        raddr = pos_c[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  ote_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_APPEND: begin
          count_r <= count_r + CW'(1);
        end
        OP_REMOVE: begin
          count_r <= count_r - CW'(1);
        end
        OP_SHUP_POS, OP_SHUP_LO, OP_SHDN_START: begin
          pend_r <= 1'b0;
        end
        OP_SHUP_STEP: begin
          pend_r <= !shup_at;
          if (shup_at && !pend_r) begin
            count_r <= count_r + CW'(1);
          end
        end
        OP_SHDN_STEP: begin
          pend_r <= shdn_more;
          if (!shdn_more && !pend_r) begin
            count_r <= count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        pos_r        <= in_position;
        val_r        <= VALUE_BITS'(in_value);
        res_rd_r     <= '0;
        res_placed_r <= '0;
      end
      OP_SHUP_POS: begin
        p_r   <= pos_c;
        ptr_r <= count_r;
      end
      OP_SHUP_LO: begin
        p_r          <= lo_r;
        ptr_r        <= count_r;
        res_placed_r <= lo_r;
      end
      OP_SHUP_STEP: begin
        if (!shup_at) begin
          wa_r  <= ptr_r[AW-1:0];
          ptr_r <= ptr_dec;
        end
      end
      OP_SHDN_START: begin
        ptr_r <= pos_c;
      end
      OP_SHDN_STEP: begin
        if (shdn_more) begin
          wa_r  <= ptr_r[AW-1:0];
          ptr_r <= ptr_inc[CW-1:0];
        end
      end
      OP_SEARCH_START: begin
        lo_r <= '0;
        hi_r <= count_r;
      end
      OP_PROBE: begin
        mid_r <= mid;
      end
      OP_NARROW: begin
        if (rdata < val_r) begin
          lo_r <= mid_r + CW'(1);
        end else begin
          hi_r <= mid_r;
        end
      end
      OP_READ_CAP: begin
        res_rd_r <= rdata;
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_status_r <= cmd.status;
      out_count_r  <= POS_W'(count_r);
      out_rd_r     <= VAL_W'(res_rd_r);
      out_placed_r <= POS_W'(res_placed_r);
    end
  end

  assign out_status       = out_status_r;
  assign out_count        = out_count_r;
  assign out_read_value   = out_rd_r;
  assign out_placed_index = out_placed_r;

endmodule

`default_nettype wire

### hw/rtl/ote_controller.sv
// controller state machine: dispatches requests and sequences search and shifts
// depends on ote_pkg
`default_nettype none

module ote_controller (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ote_pkg::CMD_W-1:0] in_cmd,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ote_pkg::ote_cmd_t         cmd,
  input  ote_pkg::ote_stat_t        stat
);

  import ote_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_PROBE,
    S_SHUP,
    S_SHDN,
    S_READ,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [ST_W-1:0]  res_st_r, res_st_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.load_out  = 1'b0;
    cmd.status    = res_st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          cmd_nxt   = in_cmd;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_st_nxt = ST_OK;
        state_nxt  = S_DONE;
        case (cmd_r)
          CMD_APPEND: begin
            if (stat.full) begin
              res_st_nxt = ST_FULL;
            end else begin
              cmd.op = OP_APPEND;
            end
          end
          CMD_REMOVE: begin
            if (stat.empty) begin
              res_st_nxt = ST_EMPTY;
            end else begin
              cmd.op = OP_REMOVE;
            end
          end
          CMD_INSERT: begin
            if (stat.pos_gt) begin
              res_st_nxt = ST_BADPOS;
            end else if (stat.full) begin
              res_st_nxt = ST_FULL;
            end else begin
              cmd.op    = OP_SHUP_POS;
              state_nxt = S_SHUP;
            end
          end
          CMD_SORTED: begin
            if (stat.full) begin
              res_st_nxt = ST_FULL;
            end else begin
              cmd.op    = OP_SEARCH_START;
              state_nxt = S_SEARCH;
            end
          end
          CMD_ERASE: begin
            if (stat.pos_ge) begin
              res_st_nxt = ST_BADPOS;
            end else begin
              cmd.op    = OP_SHDN_START;
              state_nxt = S_SHDN;
            end
          end
          CMD_READ: begin
            if (stat.pos_ge) begin
              res_st_nxt = ST_BADPOS;
            end else begin
              cmd.op    = OP_READ_ISSUE;
              state_nxt = S_READ;
            end
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        if (stat.srch_done) begin
          cmd.op    = OP_SHUP_LO;
          state_nxt = S_SHUP;
        end else begin
          cmd.op    = OP_PROBE;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.op    = OP_NARROW;
        state_nxt = S_SEARCH;
      end
      S_SHUP: begin
        cmd.op = OP_SHUP_STEP;
        if (stat.shup_done) begin
          state_nxt = S_DONE;
        end
      end
      S_SHDN: begin
        cmd.op = OP_SHDN_STEP;
        if (stat.shdn_done) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.op    = OP_READ_CAP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= CMD_APPEND;
      res_st_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      res_st_r    <= res_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/ordered_table_engine.sv
// top level of the ordered table engine: controller, datapath and checks
// depends on ote_pkg, ote_controller, ote_datapath and the macros header
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   cmd, position, value
//   out_     output     out_valid / out_stall status, count, read_value, placed_index
//
// append, remove last, rejected and unknown requests: accept, dispatch, then the result is loaded
// read at: issue, capture; insert at: tail entries move up one per cycle, then the value goes in
// sorted insert: up to ceil(log2(count+1)) probes, then insert at the placed index
// erase at: entries after position move down one at a time, as the single ram port pair allows
// reset clears the entry count and controller state; table ram contents are left as they are
// a result waits in the output register; the next request is taken once it is loaded
`default_nettype none
`include "ordered_table_engine_macros.svh"

module ordered_table_engine #(
  parameter int CAPACITY   = ote_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ote_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ote_pkg::CMD_W-1:0] in_cmd,
  input  logic [ote_pkg::POS_W-1:0] in_position,
  input  logic [ote_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ote_pkg::ST_W-1:0]  out_status,
  output logic [ote_pkg::POS_W-1:0] out_count,
  output logic [ote_pkg::VAL_W-1:0] out_read_value,
  output logic [ote_pkg::POS_W-1:0] out_placed_index
);

  import ote_pkg::*;

  ote_cmd_t  ctl_cmd;
  ote_stat_t dp_stat;

  ote_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (ctl_cmd),
    .stat      (dp_stat)
  );

  ote_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (ctl_cmd),
    .stat             (dp_stat),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_status       (out_status),
    .out_count        (out_count),
    .out_read_value   (out_read_value),
    .out_placed_index (out_placed_index)
  );

  `OTE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `OTE_ASSERT_IMPLY(a_load_when_free, clk, rst_n, ctl_cmd.load_out, !out_valid || !out_stall)
  `OTE_ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && out_status == ST_FULL, out_count == POS_W'(CAPACITY))
  `OTE_ASSERT_IMPLY(a_empty_count, clk, rst_n, out_valid && out_status == ST_EMPTY, out_count == '0)

endmodule

`default_nettype wire
